>>> rtl/contrast_enforcing_color_adjuster_top_macros.svh
// Assertion macros for the contrast adjuster.
// Used by contrast_enforcing_color_adjuster_top.sv; needs clk and rst_n in scope.
`ifndef CONTRAST_ENFORCING_COLOR_ADJUSTER_TOP_MACROS_SVH
`define CONTRAST_ENFORCING_COLOR_ADJUSTER_TOP_MACROS_SVH
// same-cycle implication
`define CECA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CECA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/ceca_pkg.sv
// Types, constants and the linearization table of the contrast adjuster.
// No dependencies.
`timescale 1ns / 1ps
package ceca_pkg;

  localparam int LIN_W = 17;
  localparam int NUM_W = 21;

  typedef logic [LIN_W-1:0] lin_tab_t [256];

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [7:0] fg_red;
    logic [7:0] fg_green;
    logic [7:0] fg_blue;
    logic [7:0] fg_alpha;
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
  } in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } out_t;

  typedef struct packed {
    logic             present;
    logic             meet;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
    rgb_t             color;
  } cand_t;

  typedef struct packed {
    logic [7:0] alpha;
    rgb_t       fg;
    logic       fg_meet;
  } side_t;

  typedef enum logic [1:0] {
    REG_REQ_RATIO = 2'd0,
    REG_DIR_MODE  = 2'd1,
    REG_UNUSED2   = 2'd2,
    REG_UNUSED3   = 2'd3
  } reg_idx_t;

  // spare code behaves like both
  typedef enum logic [1:0] {
    MODE_LIGHT = 2'd0,
    MODE_DARK  = 2'd1,
    MODE_BOTH  = 2'd2,
    MODE_SPARE = 2'd3
  } mode_t;

  localparam logic [12:0] REQ_RATIO_RST = 13'd1152;

  function automatic logic [63:0] pow5_q30(input logic [63:0] y);
    logic [63:0] p;
    p = y;
    for (int k = 0; k < 4; k++) begin
      p = (p * y) >> 30;
    end
    return p;
  endfunction

  function automatic lin_tab_t build_lin();
    lin_tab_t    t;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] r;
    for (int i = 0; i < 256; i++) begin
      if (i <= 10) begin
        t[i] = LIN_W'((64'd13107200 * 64'(i) + 64'd329460) / 64'd658920);
      end else begin
        u  = ((64'd1000 * 64'(i) + 64'd14025) << 30) / 64'd269025;
        u2 = (u * u) >> 30;
        lo = 64'd0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
          mid = lo + ((hi - lo + 64'd1) >> 1);
          if (pow5_q30(mid) <= u2) lo = mid;
          else hi = mid - 64'd1;
        end
        r    = (u2 * lo) >> 30;
        t[i] = LIN_W'((r * 64'd65536 + (64'd1 << 29)) >> 30);
      end
    end
    return t;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin();

endpackage

>>> rtl/contrast_enforcing_color_adjuster_top.sv
// The pipeline has 5 + clog2(BLEND_STEPS+1) register stages (blend, table, luminance,
// ratio, selection tree levels, output). One beat per cycle while out_stall does not hold
// the pipeline; a stage holds only while it is full and the stage after it holds. Reset
// (rst_n, synchronous) empties the pipeline, sets the required ratio to 4.5 and the
// direction mode to both.
// Depends on ceca_pkg and contrast_enforcing_color_adjuster_top_macros.svh.
`timescale 1ns / 1ps
`include "contrast_enforcing_color_adjuster_top_macros.svh"
module contrast_enforcing_color_adjuster_top #(
  parameter int BLEND_STEPS = 20
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ceca_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ceca_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [12:0]     cfg_data
);

  localparam int NC  = BLEND_STEPS + 1;
  localparam int LV  = $clog2(NC);
  localparam int P   = 1 << LV;
  localparam int NS  = 5 + LV;
  localparam int DIV = 2 * BLEND_STEPS;
  localparam int XW  = $clog2(511 * BLEND_STEPS + 1);
  localparam int SH  = XW;
  localparam int RW  = SH + 1;
  localparam int RCP = (1 << SH) / DIV;
  localparam int TS  = 4;
  localparam int OS  = NS - 1;

  typedef logic [ceca_pkg::LIN_W-1:0] lin_t;

  logic [12:0]     req_ratio_r;
  ceca_pkg::mode_t dir_mode_r;

  logic             v_r  [NS];
  logic             en   [NS];
  ceca_pkg::side_t  side_r [NS];
  ceca_pkg::side_t  side_nxt;

  ceca_pkg::rgb_t   bg1_r;
  lin_t             bglin_r [3];
  lin_t             bglum_r;
  ceca_pkg::rgb_t   col1_r [2][NC];
  ceca_pkg::rgb_t   col2_r [2][NC];
  ceca_pkg::rgb_t   col3_r [2][NC];
  lin_t             lin_r  [2][NC][3];
  lin_t             lum_r  [2][NC];
  ceca_pkg::cand_t  tree_r [0:LV][2][P];
  ceca_pkg::out_t   out_r;
  ceca_pkg::cand_t  fg_cand;
  ceca_pkg::rgb_t   out_rgb;

  function automatic logic [7:0] mix_ch(input logic [7:0] c, input logic white,
                                        input int i);
    logic [XW-1:0]    x;
    logic [XW+RW-1:0] p;
    logic [7:0]       q;
    logic [XW-1:0]    r;
    x = XW'(2 * (int'(c) * (BLEND_STEPS - i) + (white ? 255 * i : 0)) + BLEND_STEPS);
    p = (XW+RW)'(x) * (XW+RW)'(RCP);
    q = 8'(p >> SH);
    r = x - XW'(int'(q) * DIV);
    if (r >= XW'(DIV)) q = q + 8'd1;
    return q;
  endfunction

  function automatic lin_t lum(input lin_t a, input lin_t b, input lin_t c);
    logic [33:0] s;
    s = 34'(a) * 34'd13933 + 34'(b) * 34'd46871 + 34'(c) * 34'd4732 + 34'd32768;
    return lin_t'(s >> 16);
  endfunction

  function automatic ceca_pkg::cand_t mk_cand(input lin_t la, input lin_t lb,
                                              input ceca_pkg::rgb_t col,
                                              input logic [12:0] mr);
    ceca_pkg::cand_t c;
    lin_t            hi;
    lin_t            lo;
    hi = (la > lb) ? la : lb;
    lo = (la > lb) ? lb : la;
    c.present = 1'b1;
    c.num     = ceca_pkg::NUM_W'(21'(hi) * 21'd20 + 21'd65536);
    c.den     = ceca_pkg::NUM_W'(21'(lo) * 21'd20 + 21'd65536);
    c.meet    = ({5'd0, c.num, 8'd0} >= 34'(mr) * 34'(c.den));
    c.color   = col;
    return c;
  endfunction

  function automatic ceca_pkg::cand_t better(input ceca_pkg::cand_t a,
                                             input ceca_pkg::cand_t b);
    logic [2*ceca_pkg::NUM_W-1:0] pa;
    logic [2*ceca_pkg::NUM_W-1:0] pb;
    pb = (2*ceca_pkg::NUM_W)'(b.num) * (2*ceca_pkg::NUM_W)'(a.den);
    pa = (2*ceca_pkg::NUM_W)'(a.num) * (2*ceca_pkg::NUM_W)'(b.den);
    if (!b.present) return a;
    if (a.meet) return a;
    if (b.meet) return b;
    if (pb > pa) return b;
    return a;
  endfunction

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_ratio_r <= ceca_pkg::REQ_RATIO_RST;
      dir_mode_r  <= ceca_pkg::MODE_BOTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ceca_pkg::REG_REQ_RATIO: req_ratio_r <= cfg_data;
        ceca_pkg::REG_DIR_MODE:  dir_mode_r  <= ceca_pkg::mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // flow control
  always_comb begin
    en[OS] = !v_r[OS] || !out_stall;
    for (int k = OS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) v_r[k] <= 1'b0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign fg_cand = mk_cand(lum_r[0][0], bglum_r, col3_r[0][0], req_ratio_r);

  always_comb begin
    side_nxt         = side_r[2];
    side_nxt.fg_meet = fg_cand.meet;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0].alpha   <= in_data.fg_alpha;
      side_r[0].fg      <= {in_data.fg_red, in_data.fg_green, in_data.fg_blue};
      side_r[0].fg_meet <= 1'b0;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k] && k != 3) side_r[k] <= side_r[k-1];
    end
    if (en[3]) side_r[3] <= side_nxt;
  end

  // stage 0: blend steps
  always_ff @(posedge clk) begin
    if (en[0]) begin
      bg1_r <= {in_data.bg_red, in_data.bg_green, in_data.bg_blue};
      for (int d = 0; d < 2; d++) begin
        col1_r[d][0] <= {in_data.fg_red, in_data.fg_green, in_data.fg_blue};
        for (int i = 1; i < NC; i++) begin
          col1_r[d][i].r <= mix_ch(in_data.fg_red,   d == 0, i);
          col1_r[d][i].g <= mix_ch(in_data.fg_green, d == 0, i);
          col1_r[d][i].b <= mix_ch(in_data.fg_blue,  d == 0, i);
        end
      end
    end
  end

  // stage 1: linearize
  always_ff @(posedge clk) begin
    if (en[1]) begin
      bglin_r[0] <= ceca_pkg::LIN_TAB[bg1_r.r];
      bglin_r[1] <= ceca_pkg::LIN_TAB[bg1_r.g];
      bglin_r[2] <= ceca_pkg::LIN_TAB[bg1_r.b];
      for (int d = 0; d < 2; d++) begin
        for (int i = 0; i < NC; i++) begin
          col2_r[d][i]   <= col1_r[d][i];
          lin_r[d][i][0] <= ceca_pkg::LIN_TAB[col1_r[d][i].r];
          lin_r[d][i][1] <= ceca_pkg::LIN_TAB[col1_r[d][i].g];
          lin_r[d][i][2] <= ceca_pkg::LIN_TAB[col1_r[d][i].b];
        end
      end
    end
  end

  // stage 2: luminance
  always_ff @(posedge clk) begin
    if (en[2]) begin
      bglum_r <= lum(bglin_r[0], bglin_r[1], bglin_r[2]);
      for (int d = 0; d < 2; d++) begin
        for (int i = 0; i < NC; i++) begin
          col3_r[d][i] <= col2_r[d][i];
          lum_r[d][i]  <= lum(lin_r[d][i][0], lin_r[d][i][1], lin_r[d][i][2]);
        end
      end
    end
  end

  // stage 3: ratios, tree leaves
  // selection tree: first step that meets, else strictly best
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int d = 0; d < 2; d++) begin
        for (int j = 0; j < P; j++) begin
          if (j < NC) tree_r[0][d][j] <= mk_cand(lum_r[d][j], bglum_r, col3_r[d][j],
                                                 req_ratio_r);
          else tree_r[0][d][j] <= '0;
        end
      end
    end
    for (int l = 1; l <= LV; l++) begin
      if (en[3+l]) begin
        for (int d = 0; d < 2; d++) begin
          for (int j = 0; j < P / 2; j++) begin
            if (j < (P >> l)) tree_r[l][d][j] <= better(tree_r[l-1][d][2*j],
                                                        tree_r[l-1][d][2*j+1]);
            else tree_r[l][d][j] <= '0;
          end
          for (int j = P / 2; j < P; j++) tree_r[l][d][j] <= '0;
        end
      end
    end
  end

  // output stage
  logic [2*ceca_pkg::NUM_W-1:0] both_l, both_d;
  ceca_pkg::rgb_t               pick;
  ceca_pkg::cand_t              lt, dk;

  assign lt = tree_r[LV][0][0];
  assign dk = tree_r[LV][1][0];

  always_comb begin
    both_l = (2*ceca_pkg::NUM_W)'(lt.num) * (2*ceca_pkg::NUM_W)'(dk.den);
    both_d = (2*ceca_pkg::NUM_W)'(dk.num) * (2*ceca_pkg::NUM_W)'(lt.den);
    unique case (dir_mode_r)
      ceca_pkg::MODE_LIGHT: pick = lt.color;
      ceca_pkg::MODE_DARK:  pick = dk.color;
      default:              pick = (both_l >= both_d) ? lt.color : dk.color;
    endcase
    if (side_r[OS-1].fg_meet) pick = side_r[OS-1].fg;
  end

  always_ff @(posedge clk) begin
    if (en[OS]) begin
      out_r.out_red   <= pick.r;
      out_r.out_green <= pick.g;
      out_r.out_blue  <= pick.b;
      out_r.out_alpha <= side_r[OS-1].alpha;
    end
  end

  assign out_valid = v_r[OS];
  assign out_data  = out_r;
  assign out_rgb   = {out_data.out_red, out_data.out_green, out_data.out_blue};

  `CECA_ASSERT_NEXT(a_capture, in_valid && !in_stall, v_r[0], "accepted beat not captured")
  `CECA_ASSERT_NEXT(a_hold_ts, v_r[TS] && !en[TS], v_r[TS], "held tree beat dropped")
  `CECA_ASSERT_NOW(a_pass_fg, out_valid && side_r[OS].fg_meet, out_rgb == side_r[OS].fg, "fg altered")

endmodule
